[rtl/core/pce_pkg.sv]
package pce_pkg;

  // Window and sample format
  localparam int MaxSamples = 1024;
  localparam int SampleBits = 16;
  localparam int SampleW    = 16;
  localparam int CorrW      = 16;
  localparam int StatusW    = 2;
  localparam int PairW      = 11;

  // Running sum widths
  localparam int LogMax = $clog2(MaxSamples);
  localparam int CntW   = $clog2(MaxSamples + 1);
  localparam int ProdW  = 2 * SampleBits;
  localparam int SumW   = SampleBits + LogMax;
  localparam int SqW    = ProdW + LogMax - 1;
  localparam int XW     = ProdW + LogMax;

  // Finishing arithmetic widths
  localparam int VW     = ProdW + 2 * LogMax - 1;
  localparam int W      = 2 * VW + 2;
  localparam int QW     = 2 * CorrW + 1;
  localparam int RootW  = CorrW + 1;
  localparam int QCntW  = $clog2(QW);

  localparam logic [QW-1:0] OneInit = QW'(1) << (((QW - 1) / 2) * 2);
  localparam logic signed [CorrW-1:0] CorrMax = {1'b0, {(CorrW - 1){1'b1}}};

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FLAT = 2'd2,
    ST_DROP = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [SampleW-1:0] x_sample;
    logic signed [SampleW-1:0] y_sample;
    logic                      last_pair;
  } in_t;

  typedef struct packed {
    logic signed [CorrW-1:0] correlation;
    logic [StatusW-1:0]      status;
    logic [PairW-1:0]        pair_count;
  } out_t;

  typedef struct packed {
    logic [CntW-1:0]        count;
    logic signed [SumW-1:0] sum_x;
    logic signed [SumW-1:0] sum_y;
    logic [SqW-1:0]         sum_xx;
    logic [SqW-1:0]         sum_yy;
    logic signed [XW-1:0]   sum_xy;
    logic                   overflowed;
  } sums_t;

  typedef struct packed {
    logic busy;
    logic fire;
  } acc_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fin_stat_t;

  typedef enum logic [2:0] {
    ACC_IDLE,
    ACC_YY,
    ACC_XY,
    ACC_ADD,
    ACC_FIRE
  } acc_state_e;

  typedef enum logic [3:0] {
    F_IDLE,
    F_CHECK,
    F_VX_N,
    F_VX_S,
    F_VY_N,
    F_VY_S,
    F_NUM_N,
    F_NUM_S,
    F_SQN,
    F_DEN,
    F_DIV,
    F_SQRT,
    F_ROUND,
    F_DONE
  } fin_state_e;

endpackage

[rtl/core/pearson_correlation_engine.sv]
// A pair word occupies the block while one multiplier forms x*x, y*y and x*y in turn.
// The last pair of a window adds the finishing pass on one shared add/subtract unit:
// shift-add products, a 33-step divide and a 17-step root.
// A new pair is held off while a word is in the multiplier or a window is being finished.
// Reset: asynchronous, active low; clears sums, count, drop flag and all control state.
module pearson_correlation_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pce_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pce_pkg::out_t out_data_o
);
  import pce_pkg::*;

  acc_stat_t acc_stat;
  fin_stat_t fin_stat;
  sums_t     sums;
  out_t      fin_res;

  logic in_take;
  logic out_load;
  logic out_valid_q, out_valid_d;
  out_t out_data_q;

  // Hold off new words while a word is in the multiplier or a window is being finished.
  assign in_stall_o = acc_stat.busy | fin_stat.busy;
  assign in_take    = in_valid_i & ~in_stall_o;

  // Move the finished result into the output register once it is free; that same edge
  // releases the finishing unit and clears the running sums for the next window.
  assign out_load = fin_stat.done & (~out_valid_q | ~out_stall_i);

  pce_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (in_take),
    .item_i  (in_data_i),
    .clear_i (out_load),
    .stat_o  (acc_stat),
    .sums_o  (sums)
  );

  pce_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_stat.fire),
    .ack_i   (out_load),
    .sums_i  (sums),
    .stat_o  (fin_stat),
    .res_o   (fin_res)
  );

  // Output register: a result waits here while the next window streams in.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= fin_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_data_i.last_pair) |=> in_stall_o)
    else $error("last pair accepted without holding the input");

  a_one_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_stat.busy && fin_stat.busy))
    else $error("sums updated while a window is being finished");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_stat.done && !out_valid_o) |=> out_valid_o)
    else $error("finished result not moved to the output register");

endmodule

[rtl/core/pce_accum.sv]
module pce_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  pce_pkg::in_t      item_i,
  input  logic              clear_i,
  output pce_pkg::acc_stat_t stat_o,
  output pce_pkg::sums_t    sums_o
);
  import pce_pkg::*;

  acc_state_e state_q, state_d;

  logic signed [SampleBits-1:0] x_q, x_d, y_q, y_d, x_in, y_in;
  logic                         last_q, last_d;
  logic signed [SampleBits-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0]      prod_q, prod_d;

  logic [CntW-1:0]        count_q, count_d;
  logic signed [SumW-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [SqW-1:0]         sum_xx_q, sum_xx_d, sum_yy_q, sum_yy_d;
  logic signed [XW-1:0]   sum_xy_q, sum_xy_d;
  logic                   ovf_q, ovf_d;

  assign x_in = item_i.x_sample[SampleBits-1:0];
  assign y_in = item_i.y_sample[SampleBits-1:0];

  // one multiplier, three products per word
  always_comb begin
    mul_a  = x_q;
    mul_b  = y_q;
    if (state_q == ACC_IDLE) begin
      mul_a = x_in;
      mul_b = x_in;
    end else if (state_q == ACC_YY) begin
      mul_a = y_q;
    end
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    last_d   = last_q;
    count_d  = count_q;
    sum_x_d  = sum_x_q;
    sum_y_d  = sum_y_q;
    sum_xx_d = sum_xx_q;
    sum_yy_d = sum_yy_q;
    sum_xy_d = sum_xy_q;
    ovf_d    = ovf_q;
    unique case (state_q)
      ACC_IDLE: begin
        if (take_i) begin
          x_d    = x_in;
          y_d    = y_in;
          last_d = item_i.last_pair;
          if (count_q < CntW'(MaxSamples)) begin
            count_d = count_q + CntW'(1);
            sum_x_d = sum_x_q + SumW'(x_in);
            sum_y_d = sum_y_q + SumW'(y_in);
            state_d = ACC_YY;
          end else begin
            ovf_d   = 1'b1;
            state_d = item_i.last_pair ? ACC_FIRE : ACC_IDLE;
          end
        end
      end
      ACC_YY: begin
        sum_xx_d = sum_xx_q + SqW'(prod_q);
        state_d  = ACC_XY;
      end
      ACC_XY: begin
        sum_yy_d = sum_yy_q + SqW'(prod_q);
        state_d  = ACC_ADD;
      end
      ACC_ADD: begin
        sum_xy_d = sum_xy_q + XW'(prod_q);
        state_d  = last_q ? ACC_FIRE : ACC_IDLE;
      end
      ACC_FIRE: begin
        state_d = ACC_IDLE;
      end
      default: begin
        state_d = ACC_IDLE;
      end
    endcase
    if (clear_i) begin
      count_d  = '0;
      sum_x_d  = '0;
      sum_y_d  = '0;
      sum_xx_d = '0;
      sum_yy_d = '0;
      sum_xy_d = '0;
      ovf_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ACC_IDLE;
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sum_x_q  <= sum_x_d;
      sum_y_q  <= sum_y_d;
      sum_xx_q <= sum_xx_d;
      sum_yy_q <= sum_yy_d;
      sum_xy_q <= sum_xy_d;
      ovf_q    <= ovf_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    prod_q <= prod_d;
  end

  assign stat_o.busy = (state_q != ACC_IDLE);
  assign stat_o.fire = (state_q == ACC_FIRE);

  assign sums_o.count      = count_q;
  assign sums_o.sum_x      = sum_x_q;
  assign sums_o.sum_y      = sum_y_q;
  assign sums_o.sum_xx     = sum_xx_q;
  assign sums_o.sum_yy     = sum_yy_q;
  assign sums_o.sum_xy     = sum_xy_q;
  assign sums_o.overflowed = ovf_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSamples))
    else $error("pair count beyond window size");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CntW'(MaxSamples)))
    else $error("drop flag set with window not full");

endmodule

[rtl/core/pce_finish.sv]
module pce_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               ack_i,
  input  pce_pkg::sums_t     sums_i,
  output pce_pkg::fin_stat_t stat_o,
  output pce_pkg::out_t      res_o
);
  import pce_pkg::*;

  fin_state_e state_q, state_d;

  logic [W-1:0]     acc_q, acc_d, mca_q, mca_d, rem_q, rem_d, den_q, den_d;
  logic [VW-1:0]    mcb_q, mcb_d, vx_q, vx_d, vy_q, vy_d;
  logic             sub_q, sub_d, neg_q, neg_d;
  logic [QW-1:0]    quo_q, quo_d, one_q, one_d, quo_new;
  logic [QCntW-1:0] cnt_q, cnt_d;
  out_t             res_q, res_d;

  logic [W-1:0]     alu_a, alu_b, mag;
  logic             alu_sub;
  logic [W:0]       alu_res;
  logic             mb_zero, in_mul, ge;

  logic [SumW-1:0]  abs_x, abs_y;
  logic [XW-1:0]    abs_xy;
  logic [RootW-1:0] root_inc, q_mag, q_neg;
  logic signed [CorrW-1:0] corr_pos;

  assign abs_x  = sums_i.sum_x[SumW-1] ? SumW'(-sums_i.sum_x) : SumW'(sums_i.sum_x);
  assign abs_y  = sums_i.sum_y[SumW-1] ? SumW'(-sums_i.sum_y) : SumW'(sums_i.sum_y);
  assign abs_xy = sums_i.sum_xy[XW-1] ? XW'(-sums_i.sum_xy) : XW'(sums_i.sum_xy);

  assign mb_zero = (mcb_q == '0);
  assign in_mul  = (state_q == F_VX_N) || (state_q == F_VX_S) || (state_q == F_VY_N) ||
                   (state_q == F_VY_S) || (state_q == F_NUM_N) || (state_q == F_NUM_S) ||
                   (state_q == F_SQN) || (state_q == F_DEN);

  // shared add/subtract unit
  always_comb begin
    alu_a   = acc_q;
    alu_b   = mca_q;
    alu_sub = sub_q;
    if (state_q == F_DIV) begin
      alu_a   = (cnt_q == '0) ? rem_q : {rem_q[W-2:0], 1'b0};
      alu_b   = den_q;
      alu_sub = 1'b1;
    end else if (state_q == F_SQRT) begin
      alu_a   = rem_q;
      alu_b   = W'(quo_q | one_q);
      alu_sub = 1'b1;
    end else if ((state_q == F_NUM_S) && mb_zero) begin
      alu_a   = '0;
      alu_b   = acc_q;
      alu_sub = 1'b1;
    end
  end

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign ge      = ~alu_res[W];
  assign mag     = acc_q[W-1] ? alu_res[W-1:0] : acc_q;
  assign quo_new = {quo_q[QW-2:0], ge};

  // round half up on the root, then sign and saturate
  assign root_inc = quo_q[RootW-1:0] + RootW'(1);
  assign q_mag    = root_inc >> 1;
  assign q_neg    = ~q_mag + RootW'(1);
  assign corr_pos = (q_mag[RootW-1:CorrW-1] != '0) ? CorrMax : q_mag[CorrW-1:0];

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    mca_d   = mca_q;
    mcb_d   = mcb_q;
    sub_d   = sub_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    one_d   = one_q;
    cnt_d   = cnt_q;
    res_d   = res_q;

    // shift-add step
    if (in_mul && !mb_zero) begin
      acc_d = mcb_q[0] ? alu_res[W-1:0] : acc_q;
      mca_d = mca_q << 1;
      mcb_d = mcb_q >> 1;
    end

    unique case (state_q)
      F_IDLE: begin
        if (start_i) state_d = F_CHECK;
      end
      F_CHECK: begin
        res_d.pair_count = PairW'(sums_i.count);
        if (sums_i.count < CntW'(2)) begin
          res_d.correlation = '0;
          res_d.status      = ST_FEW;
          state_d           = F_DONE;
        end else begin
          acc_d   = '0;
          mca_d   = W'(sums_i.sum_xx);
          mcb_d   = VW'(sums_i.count);
          sub_d   = 1'b0;
          state_d = F_VX_N;
        end
      end
      F_VX_N: begin
        if (mb_zero) begin
          mca_d   = W'(abs_x);
          mcb_d   = VW'(abs_x);
          sub_d   = 1'b1;
          state_d = F_VX_S;
        end
      end
      F_VX_S: begin
        if (mb_zero) begin
          vx_d    = acc_q[VW-1:0];
          acc_d   = '0;
          mca_d   = W'(sums_i.sum_yy);
          mcb_d   = VW'(sums_i.count);
          sub_d   = 1'b0;
          state_d = F_VY_N;
        end
      end
      F_VY_N: begin
        if (mb_zero) begin
          mca_d   = W'(abs_y);
          mcb_d   = VW'(abs_y);
          sub_d   = 1'b1;
          state_d = F_VY_S;
        end
      end
      F_VY_S: begin
        if (mb_zero) begin
          vy_d    = acc_q[VW-1:0];
          acc_d   = '0;
          mca_d   = W'(abs_xy);
          mcb_d   = VW'(sums_i.count);
          sub_d   = sums_i.sum_xy[XW-1];
          state_d = F_NUM_N;
        end
      end
      F_NUM_N: begin
        if (mb_zero) begin
          mca_d   = W'(abs_x);
          mcb_d   = VW'(abs_y);
          sub_d   = (sums_i.sum_x[SumW-1] == sums_i.sum_y[SumW-1]);
          state_d = F_NUM_S;
        end
      end
      F_NUM_S: begin
        if (mb_zero) begin
          neg_d = acc_q[W-1];
          if ((vx_q == '0) || (vy_q == '0)) begin
            res_d.correlation = '0;
            res_d.status      = ST_FLAT;
            state_d           = F_DONE;
          end else begin
            acc_d   = '0;
            mca_d   = W'(mag[VW-1:0]);
            mcb_d   = mag[VW-1:0];
            sub_d   = 1'b0;
            state_d = F_SQN;
          end
        end
      end
      F_SQN: begin
        if (mb_zero) begin
          rem_d   = acc_q;
          acc_d   = '0;
          mca_d   = W'(vx_q);
          mcb_d   = vy_q;
          sub_d   = 1'b0;
          state_d = F_DEN;
        end
      end
      F_DEN: begin
        if (mb_zero) begin
          den_d   = acc_q;
          cnt_d   = '0;
          quo_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // restoring divide: quotient of num^2 * 2^32 by the variance product
        rem_d = ge ? alu_res[W-1:0] : alu_a;
        cnt_d = cnt_q + QCntW'(1);
        quo_d = quo_new;
        if (cnt_q == QCntW'(QW - 1)) begin
          rem_d   = W'(quo_new);
          quo_d   = '0;
          one_d   = OneInit;
          state_d = F_SQRT;
        end
      end
      F_SQRT: begin
        // digit-by-digit integer square root, root builds up in quo
        if (ge) begin
          rem_d = alu_res[W-1:0];
          quo_d = (quo_q >> 1) | one_q;
        end else begin
          quo_d = quo_q >> 1;
        end
        one_d = one_q >> 2;
        if (one_q[0]) state_d = F_ROUND;
      end
      F_ROUND: begin
        res_d.correlation = neg_q ? q_neg[CorrW-1:0] : corr_pos;
        res_d.status      = sums_i.overflowed ? ST_DROP : ST_OK;
        state_d           = F_DONE;
      end
      F_DONE: begin
        if (ack_i) state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mca_q <= mca_d;
    mcb_q <= mcb_d;
    sub_q <= sub_d;
    vx_q  <= vx_d;
    vy_q  <= vy_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    one_q <= one_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign stat_o.busy = (state_q != F_IDLE);
  assign stat_o.done = (state_q == F_DONE);
  assign res_o       = res_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> (den_q != '0))
    else $error("divide entered with zero denominator");

  a_root_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_SQRT) |-> $onehot(one_q))
    else $error("square root digit marker lost");

endmodule
